[sv/assert_macros.svh]
// Assertion helpers shared by the RTL. With SYNTH defined they expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property that must hold at every rising edge outside reset.
`define FCC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen at a rising edge outside reset.
`define FCC_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define FCC_ASSERT(label, clk, rst_n, prop, msg)

`define FCC_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

[sv/fcc_pkg.sv]
package fcc_pkg;

	localparam int PLANE_COUNT = 6;
	localparam int AXES        = 3;

	// Q16.16 operand widths.
	localparam int VAL_W  = 32;
	localparam int HALF_W = 31;
	localparam int ADDR_W = 4;

	// Plane coefficients carry one extra bit for the sum or difference.
	localparam int COEF_W = VAL_W + 1;
	localparam int PROD_W = COEF_W + VAL_W;
	localparam int TERM_W = PROD_W + 1;
	localparam int ACC_W  = TERM_W + 2;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_TEST  = 1'b1;

	typedef struct packed {
		logic                     is_test;
		logic [ADDR_W-1:0]        addr;
		logic [VAL_W-1:0]         value;
		logic signed [VAL_W-1:0]  cx;
		logic signed [VAL_W-1:0]  cy;
		logic signed [VAL_W-1:0]  cz;
		logic [HALF_W-1:0]        half;
	} fcc_op_t;

endpackage

[sv/fcc_fifo.sv]
module fcc_fifo #(
	parameter int W = 8,
	parameter int D = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);

	localparam int PW = $clog2(D);
	localparam int CW = $clog2(D + 1);

	logic [W-1:0]  mem_q [D];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (cnt_q == CW'(D));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(D - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(D - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

endmodule

[sv/fcc_front.sv]
module fcc_front import fcc_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic                     cmd,
	input  logic [1:0]               col_index,
	input  logic [1:0]               row_index,
	input  logic signed [VAL_W-1:0]  element_value,
	input  logic signed [VAL_W-1:0]  center_x,
	input  logic signed [VAL_W-1:0]  center_y,
	input  logic signed [VAL_W-1:0]  center_z,
	input  logic [HALF_W-1:0]        half_size,
	input  logic                     op_pop,
	output fcc_op_t                  op,
	output logic                     op_empty
);

	fcc_op_t in_op;

	// Classify the beat and form the store address of a write.
	always_comb begin
		in_op.is_test = (cmd == CMD_TEST);
		in_op.addr    = {col_index, row_index};
		in_op.value   = element_value;
		in_op.cx      = center_x;
		in_op.cy      = center_y;
		in_op.cz      = center_z;
		in_op.half    = half_size;
	end

	fcc_fifo #(
		.W($bits(fcc_op_t)),
		.D(DEPTH)
	) u_op_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (in_op),
		.full  (full),
		.pop   (op_pop),
		.rdata (op),
		.empty (op_empty)
	);

endmodule

[sv/fcc_back.sv]
module fcc_back import fcc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  fcc_op_t op,
	input  logic    op_empty,
	output logic    op_pop,
	input  logic    res_full,
	output logic    res_push,
	output logic    res_inside
);

	logic [VAL_W-1:0] mat_q [16];

	logic advance;
	logic v_s1, v_s2, v_s3, v_s4;

	logic signed [COEF_W-1:0] n_d  [PLANE_COUNT][AXES];
	logic signed [COEF_W-1:0] d_d  [PLANE_COUNT];
	logic [PLANE_COUNT-1:0]   nz_d;

	logic signed [COEF_W-1:0] n_s1 [PLANE_COUNT][AXES];
	logic signed [COEF_W-1:0] d_s1 [PLANE_COUNT];
	logic [PLANE_COUNT-1:0]   nz_s1;
	logic signed [VAL_W-1:0]  c_s1 [AXES];
	logic [HALF_W-1:0]        h_s1;
	logic signed [VAL_W-1:0]  hs_s1;

	logic signed [PROD_W-1:0] pc_s2 [PLANE_COUNT][AXES];
	logic signed [PROD_W-1:0] ph_s2 [PLANE_COUNT][AXES];
	logic                     neg_s2 [PLANE_COUNT][AXES];
	logic signed [COEF_W-1:0] d_s2 [PLANE_COUNT];
	logic [PLANE_COUNT-1:0]   nz_s2;

	logic signed [TERM_W-1:0] s_s3 [PLANE_COUNT][AXES];
	logic signed [COEF_W-1:0] d_s3 [PLANE_COUNT];
	logic [PLANE_COUNT-1:0]   nz_s3;

	logic signed [ACC_W-1:0]  acc_d [PLANE_COUNT];
	logic [PLANE_COUNT-1:0]   rej_d;
	logic                     inside_s4;

	// The whole pipe holds while a finished beat cannot enter the result queue.
	assign advance    = !v_s4 || !res_full;
	assign op_pop     = advance && !op_empty;
	assign res_push   = v_s4 && !res_full;
	assign res_inside = inside_s4;
	assign hs_s1      = $signed({1'b0, h_s1});

	// Plane p uses row p/2; odd planes take the difference with row 3.
	always_comb begin
		logic signed [COEF_W-1:0] e3;
		logic signed [COEF_W-1:0] ek;
		for (int p = 0; p < PLANE_COUNT; p++) begin
			for (int a = 0; a < AXES; a++) begin
				e3 = $signed(mat_q[4'(a * 4 + 3)]);
				ek = $signed(mat_q[4'(a * 4 + (p >> 1))]);
				n_d[p][a] = ((p & 1) != 0) ? e3 - ek : e3 + ek;
			end
			e3 = $signed(mat_q[4'(15)]);
			ek = $signed(mat_q[4'(12 + (p >> 1))]);
			d_d[p]  = ((p & 1) != 0) ? e3 - ek : e3 + ek;
			nz_d[p] = (n_d[p][0] != '0) || (n_d[p][1] != '0) || (n_d[p][2] != '0);
		end
	end

	always_comb begin
		for (int p = 0; p < PLANE_COUNT; p++) begin
			acc_d[p] = ACC_W'(s_s3[p][0]) + ACC_W'(s_s3[p][1]) + ACC_W'(s_s3[p][2])
				+ ACC_W'($signed({d_s3[p], 16'd0}));
			// A plane with a zero normal never rejects.
			rej_d[p] = acc_d[p][ACC_W-1] && nz_s3[p];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				mat_q[i] <= '0;
			end
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (op_pop && !op.is_test) begin
				mat_q[op.addr] <= op.value;
			end
			if (advance) begin
				v_s1 <= op_pop && op.is_test;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			n_s1  <= n_d;
			d_s1  <= d_d;
			nz_s1 <= nz_d;
			c_s1[0] <= op.cx;
			c_s1[1] <= op.cy;
			c_s1[2] <= op.cz;
			h_s1  <= op.half;

			// The corner term |n|*h is formed as n*h and its sign fixed in the next stage.
			for (int p = 0; p < PLANE_COUNT; p++) begin
				for (int a = 0; a < AXES; a++) begin
					pc_s2[p][a]  <= n_s1[p][a] * c_s1[a];
					ph_s2[p][a]  <= n_s1[p][a] * hs_s1;
					neg_s2[p][a] <= n_s1[p][a][COEF_W-1];
				end
			end
			d_s2  <= d_s1;
			nz_s2 <= nz_s1;

			for (int p = 0; p < PLANE_COUNT; p++) begin
				for (int a = 0; a < AXES; a++) begin
					s_s3[p][a] <= neg_s2[p][a]
						? TERM_W'(pc_s2[p][a]) - TERM_W'(ph_s2[p][a])
						: TERM_W'(pc_s2[p][a]) + TERM_W'(ph_s2[p][a]);
				end
			end
			d_s3  <= d_s2;
			nz_s3 <= nz_s2;

			inside_s4 <= !(|rej_d);
		end
	end

endmodule

[sv/frustum_cube_cull.sv]
// Frustum culling of axis-aligned cubes against a stored view-projection matrix.
// Input channel: queue-like, a beat is taken when push is high and full is low.
// A write beat (cmd low) stores element_value at column col_index, row row_index
// of the column-major matrix and yields no result. A test beat (cmd high) gives
// center_x/y/z and half_size and yields one result, inside_res.
// Result channel: while empty is low the oldest result sits on inside_res; it is
// taken when pop is high. Results leave in the order of their tests.
// Throughput is one beat per cycle while nothing stalls. A taken test beat passes
// the input queue and then four pipeline stages (plane forming, multipliers,
// per-axis sums, plane sums and sign check) before its result is queued.
// The matrix is read when a beat leaves the input queue, so a test always sees
// every write that was taken before it.
// Reset clears the matrix to zero (every plane then passes), both queues and
// the pipeline. When the receiver stops popping, the result queue fills, the
// pipeline holds, then the input queue fills and full rises.
`include "assert_macros.svh"

module frustum_cube_cull import fcc_pkg::*; #(
	parameter int IN_DEPTH  = 4,
	parameter int OUT_DEPTH = 4
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	output logic                     full,
	input  logic                     cmd,
	input  logic [1:0]               col_index,
	input  logic [1:0]               row_index,
	input  logic signed [VAL_W-1:0]  element_value,
	input  logic signed [VAL_W-1:0]  center_x,
	input  logic signed [VAL_W-1:0]  center_y,
	input  logic signed [VAL_W-1:0]  center_z,
	input  logic [HALF_W-1:0]        half_size,
	output logic                     empty,
	input  logic                     pop,
	output logic                     inside_res
);

	fcc_op_t op;
	logic    op_empty;
	logic    op_pop;
	logic    res_full;
	logic    res_push;
	logic    res_inside;

	fcc_front #(
		.DEPTH(IN_DEPTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.cmd          (cmd),
		.col_index    (col_index),
		.row_index    (row_index),
		.element_value(element_value),
		.center_x     (center_x),
		.center_y     (center_y),
		.center_z     (center_z),
		.half_size    (half_size),
		.op_pop       (op_pop),
		.op           (op),
		.op_empty     (op_empty)
	);

	fcc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.op_empty  (op_empty),
		.op_pop    (op_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res_inside(res_inside)
	);

	fcc_fifo #(
		.W(1),
		.D(OUT_DEPTH)
	) u_res_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_inside),
		.full  (res_full),
		.pop   (pop),
		.rdata (inside_res),
		.empty (empty)
	);

	`FCC_NEVER(a_res_overflow, clk, arst_n, res_push && res_full, "result beat pushed into full queue")
	`FCC_ASSERT(a_op_pop_valid, clk, arst_n, op_pop |-> !op_empty, "op popped from empty queue")
	`FCC_ASSERT(a_res_lands, clk, arst_n, res_push |=> !empty, "pushed result not visible")

endmodule
